[rtl/slt_pkg.sv]
// ----------------------------------------------------------------------------
// slt_pkg
// Shared types and constants for the sorted list table: request and response
// items, operation codes and storage sizes.
// ----------------------------------------------------------------------------
package slt_pkg;

    // storage sizes
    localparam int CAPACITY = 64;
    localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = 7;
    localparam int DATA_W   = 32;

    // operation codes
    localparam logic [1:0] FUNC_INSERT     = 2'd0;
    localparam logic [1:0] FUNC_REMOVE_ONE = 2'd1;
    localparam logic [1:0] FUNC_REMOVE_ALL = 2'd2;

    // request item
    typedef struct packed {
        logic [1:0]               func;
        logic signed [DATA_W-1:0] value;
    } req_t;

    // response item
    typedef struct packed {
        logic             ok;
        logic [CNT_W-1:0] removed_count;
        logic [CNT_W-1:0] list_size;
    } rsp_t;

endpackage

[rtl/slt_ram.sv]
// ----------------------------------------------------------------------------
// slt_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module slt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

[rtl/sorted_list_table_core.sv]
// ----------------------------------------------------------------------------
// sorted_list_table_core
// Sorted list of signed values with insert, remove-first and remove-all.
// ----------------------------------------------------------------------------
// Requests enter on req (func, value) under req_valid / req_stall; one
// response per request leaves on rsp (ok, removed_count, list_size) under
// rsp_valid / rsp_stall. The block works on one request at a time and holds
// req_stall high while busy.
// The entries live in one RAM and are walked one entry per cycle through its
// single read port: an insert shifts each larger entry up, a remove visits
// every entry held, and a full list or unused op goes straight to the
// response. The next request is taken in the cycle after the response is
// loaded into the output register, even if the receiver still stalls it; a
// stalled response holds its value, and a finished request waits until the
// output register is free.
// Reset clears the entry count and all control; RAM contents need no clear
// since only entries below the count are read.
// ----------------------------------------------------------------------------
module sorted_list_table_core (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  slt_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output slt_pkg::rsp_t rsp
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_INS,
        S_REM,
        S_DONE
    } state_t;

    state_t                          state_reg, state_next;
    logic                            op_all_reg, op_all_next;
    logic signed [slt_pkg::DATA_W-1:0] value_reg, value_next;
    logic [slt_pkg::CNT_W-1:0]       count_reg, count_next;
    logic [slt_pkg::CNT_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [slt_pkg::CNT_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [slt_pkg::CNT_W-1:0]       gone_reg, gone_next;
    logic                            pend_reg, pend_next;
    logic [slt_pkg::ADDR_W-1:0]      pend_addr_reg, pend_addr_next;
    logic                            ok_reg, ok_next;
    logic                            rsp_valid_reg, rsp_valid_next;
    slt_pkg::rsp_t                   rsp_reg, rsp_next;

    logic                            ram_we;
    logic [slt_pkg::ADDR_W-1:0]      ram_waddr;
    logic [slt_pkg::DATA_W-1:0]      ram_wdata;
    logic [slt_pkg::ADDR_W-1:0]      ram_raddr;
    logic [slt_pkg::DATA_W-1:0]      ram_rdata;
    logic [slt_pkg::CNT_W-1:0]       rd_ptr_dec;
    logic                            entry_greater;
    logic                            entry_match;

    // entry storage
    slt_ram #(
        .WIDTH (slt_pkg::DATA_W),
        .DEPTH (slt_pkg::CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // compares on the entry just read: greater for insert, match for remove
    assign rd_ptr_dec    = rd_ptr_reg - 1'b1;
    assign entry_greater = $signed(ram_rdata) > value_reg;
    assign entry_match   = (ram_rdata == value_reg) && (op_all_reg || (gone_reg == '0));

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        op_all_next    = op_all_reg;
        value_next     = value_reg;
        count_next     = count_reg;
        rd_ptr_next    = rd_ptr_reg;
        wr_ptr_next    = wr_ptr_reg;
        gone_next      = gone_reg;
        pend_next      = pend_reg;
        pend_addr_next = pend_addr_reg;
        ok_next        = ok_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        ram_we         = 1'b0;
        ram_waddr      = '0;
        ram_wdata      = '0;
        ram_raddr      = '0;

        // output register drains
        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    value_next  = req.value;
                    pend_next   = 1'b0;
                    gone_next   = '0;
                    wr_ptr_next = '0;
                    ok_next     = 1'b0;
                    case (req.func)
                        slt_pkg::FUNC_INSERT:
                        begin
                            if (count_reg >= slt_pkg::CNT_W'(slt_pkg::CAPACITY))
                            begin
                                state_next = S_DONE;
                            end
                            else
                            begin
                                rd_ptr_next = count_reg;
                                state_next  = S_INS;
                            end
                        end
                        slt_pkg::FUNC_REMOVE_ONE, slt_pkg::FUNC_REMOVE_ALL:
                        begin
                            op_all_next = (req.func == slt_pkg::FUNC_REMOVE_ALL);
                            rd_ptr_next = '0;
                            state_next  = S_REM;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            S_INS:
            begin
                // walk downward, one read per cycle
                if (rd_ptr_reg != '0)
                begin
                    ram_raddr      = rd_ptr_dec[slt_pkg::ADDR_W-1:0];
                    rd_ptr_next    = rd_ptr_dec;
                    pend_next      = 1'b1;
                    pend_addr_next = rd_ptr_dec[slt_pkg::ADDR_W-1:0];
                end
                else
                begin
                    pend_next = 1'b0;
                end

                // shift a larger entry up, or drop the new value in place
                if (pend_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = pend_addr_reg + 1'b1;
                    if (entry_greater)
                    begin
                        ram_wdata = ram_rdata;
                    end
                    else
                    begin
                        ram_wdata  = value_reg;
                        count_next = count_reg + 1'b1;
                        ok_next    = 1'b1;
                        state_next = S_DONE;
                    end
                end
                else if (rd_ptr_reg == '0)
                begin
                    ram_we     = 1'b1;
                    ram_waddr  = '0;
                    ram_wdata  = value_reg;
                    count_next = count_reg + 1'b1;
                    ok_next    = 1'b1;
                    state_next = S_DONE;
                end
            end

            S_REM:
            begin
                // walk upward, one read per cycle
                if (rd_ptr_reg != count_reg)
                begin
                    ram_raddr   = rd_ptr_reg[slt_pkg::ADDR_W-1:0];
                    rd_ptr_next = rd_ptr_reg + 1'b1;
                    pend_next   = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                end

                // drop matches, compact the rest
                if (pend_reg)
                begin
                    if (entry_match)
                    begin
                        gone_next = gone_reg + 1'b1;
                    end
                    else
                    begin
                        ram_we      = 1'b1;
                        ram_waddr   = wr_ptr_reg[slt_pkg::ADDR_W-1:0];
                        ram_wdata   = ram_rdata;
                        wr_ptr_next = wr_ptr_reg + 1'b1;
                    end
                end
                else if (rd_ptr_reg == count_reg)
                begin
                    count_next = wr_ptr_reg;
                    ok_next    = (gone_reg != '0);
                    state_next = S_DONE;
                end
            end

            S_DONE:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_next.ok            = ok_reg;
                    rsp_next.removed_count = gone_reg;
                    rsp_next.list_size     = count_reg;
                    rsp_valid_next         = 1'b1;
                    state_next             = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            pend_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
            rsp_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            pend_reg      <= pend_next;
            rsp_valid_reg <= rsp_valid_next;
            rsp_reg       <= rsp_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        op_all_reg    <= op_all_next;
        value_reg     <= value_next;
        rd_ptr_reg    <= rd_ptr_next;
        wr_ptr_reg    <= wr_ptr_next;
        gone_reg      <= gone_next;
        pend_addr_reg <= pend_addr_next;
        ok_reg        <= ok_next;
    end

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

[rtl/slt_checker.sv]
// ----------------------------------------------------------------------------
// slt_checker
// Port-level checks for the sorted list table, bound to the top level.
// ----------------------------------------------------------------------------
module slt_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          req_valid,
    input logic          req_stall,
    input slt_pkg::req_t req,
    input logic          rsp_valid,
    input logic          rsp_stall,
    input slt_pkg::rsp_t rsp
);

    // a stalled response stays valid
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid)
        else $error("response dropped while stalled");

    // a stalled response holds its value
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> $stable(rsp))
        else $error("response changed while stalled");

    // one item at a time: busy right after an accept
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("request taken while busy");

    // size never exceeds capacity
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp.list_size <= slt_pkg::CNT_W'(slt_pkg::CAPACITY))
        else $error("list size above capacity");

    // a failed request removes nothing
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.ok |-> rsp.removed_count == '0)
        else $error("removed count without success");

endmodule

bind sorted_list_table_core slt_checker u_slt_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);

[test/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for sorted_list_table_core. A queue of pending requests
// feeds a clocked driver; every accepted request runs through a local sorted
// list predictor, and a clocked monitor compares each response field by field
// against the oldest prediction. Both sides insert random idle cycles, the
// receiver holds off once for a long stretch, and phases cover duplicates,
// a full list, removal of all entries and the unused operation code.
// ----------------------------------------------------------------------------
module tb_top;
    import slt_pkg::*;

    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    localparam int HOLD_CYCLES  = 400;
    localparam int LIMIT_CYCLES = 400000;
    localparam int DRAIN_CYCLES = 100;

    typedef struct {
        req_t item;
        int   gap;
        bit   drain_first;
    } pending_t;

    logic  clk       = 1'b0;
    logic  rst_n     = 1'b0;
    logic  req_valid = 1'b0;
    logic  req_stall;
    req_t  req       = '0;
    logic  rsp_valid;
    logic  rsp_stall = 1'b0;
    rsp_t  rsp;

    // predictor state
    logic signed [DATA_W-1:0] model_vals [CAPACITY];
    int model_count = 0;

    // stimulus and scoreboard
    pending_t pending_reqs [$];
    rsp_t     expected_rsps [$];
    logic [DATA_W-1:0] value_pool [8];
    int  n_sent = 0;
    int  n_got = 0;
    int  n_errors = 0;
    int  cycle_count = 0;
    bit  quiet_mode = 1'b0;
    int  hold_trigger = 0;
    int  hold_seen;
    int  hold_left;
    int  stall_left;
    int  gap_left;
    bit  gap_loaded;

    // run statistics
    int  full_rejects = 0;
    int  removal_hits = 0;
    int  peak_removed = 0;
    int  peak_size = 0;

    sorted_list_table_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always #5 clk = ~clk;

    // predicted response of one request, updates the local list
    function automatic rsp_t sorted_list_apply(req_t r);
        rsp_t res;
        int pos;
        int wr;
        int gone;
        res = '0;
        case (r.func)
            FUNC_INSERT:
            begin
                if (model_count < CAPACITY)
                begin
                    pos = model_count;
                    while (pos > 0 && $signed(model_vals[pos-1]) > $signed(r.value))
                    begin
                        model_vals[pos] = model_vals[pos-1];
                        pos--;
                    end
                    model_vals[pos] = r.value;
                    model_count++;
                    res.ok = 1'b1;
                end
                else
                    full_rejects++;
            end
            FUNC_REMOVE_ONE, FUNC_REMOVE_ALL:
            begin
                wr = 0;
                gone = 0;
                for (int rd = 0; rd < model_count; rd++)
                begin
                    if (model_vals[rd] == r.value && (r.func == FUNC_REMOVE_ALL || gone == 0))
                        gone++;
                    else
                    begin
                        model_vals[wr] = model_vals[rd];
                        wr++;
                    end
                end
                model_count = wr;
                res.ok = (gone > 0);
                res.removed_count = gone[CNT_W-1:0];
                if (gone > 0)
                    removal_hits++;
                if (gone > peak_removed)
                    peak_removed = gone;
            end
            default: ;
        endcase
        if (model_count > peak_size)
            peak_size = model_count;
        res.list_size = model_count[CNT_W-1:0];
        return res;
    endfunction

    function automatic int draw_gap();
        return quiet_mode ? 0 : int'($urandom_range(0, 14));
    endfunction

    task automatic queue_request(input logic [1:0] f, input logic [DATA_W-1:0] v,
                                 input bit drain);
        pending_t p;
        p.item.func = f;
        p.item.value = v;
        p.gap = draw_gap();
        p.drain_first = drain;
        pending_reqs.push_back(p);
    endtask

    // mostly values from a small pool so removes find matches
    function automatic logic [DATA_W-1:0] pick_value();
        if ($urandom_range(0, 3) == 0)
            return $urandom();
        return value_pool[$urandom_range(0, 7)];
    endfunction

    function automatic logic [1:0] pick_func(int w_ins, int w_one, int w_all);
        int r;
        r = $urandom_range(0, 99);
        if (r < w_ins)
            return FUNC_INSERT;
        if (r < w_ins + w_one)
            return FUNC_REMOVE_ONE;
        if (r < w_ins + w_one + w_all)
            return FUNC_REMOVE_ALL;
        return FUNC_UNUSED;
    endfunction

    task automatic run_random(input int count, input int w_ins, input int w_one,
                              input int w_all, input bit drain);
        value_pool[0] = 32'h8000_0000;
        value_pool[1] = 32'h7fff_ffff;
        for (int i = 2; i < 8; i++)
            value_pool[i] = $urandom();
        for (int i = 0; i < count; i++)
            queue_request(pick_func(w_ins, w_one, w_all), pick_value(), drain && i == 0);
    endtask

    task automatic wait_queue_empty();
        while (pending_reqs.size() != 0)
            @(negedge clk);
    endtask

    // request driver
    always @(posedge clk or negedge rst_n)
    begin : req_driver
        bit offer;
        offer = req_valid;
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req <= '0;
            gap_left = 0;
            gap_loaded = 1'b0;
        end
        else
        begin
            if (req_valid && !req_stall)
            begin
                expected_rsps.push_back(sorted_list_apply(req));
                n_sent++;
                offer = 1'b0;
            end
            if (!offer && pending_reqs.size() > 0)
            begin
                if (!gap_loaded)
                begin
                    gap_left = pending_reqs[0].gap;
                    gap_loaded = 1'b1;
                end
                if (gap_left > 0)
                    gap_left--;
                else if (!pending_reqs[0].drain_first || n_sent == n_got)
                begin
                    req <= pending_reqs[0].item;
                    void'(pending_reqs.pop_front());
                    offer = 1'b1;
                    gap_loaded = 1'b0;
                end
            end
            req_valid <= offer;
        end
    end

    // response monitor and receiver stall
    always @(posedge clk or negedge rst_n)
    begin : rsp_monitor
        rsp_t want;
        if (!rst_n)
        begin
            rsp_stall <= 1'b0;
            stall_left = 0;
            hold_left = 0;
            hold_seen = 0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (expected_rsps.size() == 0)
                begin
                    $display("%0t: response with no request pending, actual %p", $time, rsp);
                    n_errors++;
                end
                else
                begin
                    want = expected_rsps.pop_front();
                    if (rsp.ok !== want.ok)
                    begin
                        $display("%0t: ok mismatch, expected %0d, actual %0d",
                                 $time, want.ok, rsp.ok);
                        n_errors++;
                    end
                    if (rsp.removed_count !== want.removed_count)
                    begin
                        $display("%0t: removed_count mismatch, expected %0d, actual %0d",
                                 $time, want.removed_count, rsp.removed_count);
                        n_errors++;
                    end
                    if (rsp.list_size !== want.list_size)
                    begin
                        $display("%0t: list_size mismatch, expected %0d, actual %0d",
                                 $time, want.list_size, rsp.list_size);
                        n_errors++;
                    end
                end
                n_got <= n_got + 1;
                stall_left = draw_gap();
            end
            else if (rsp_valid && stall_left > 0)
                stall_left--;
            // long hold-off requested by the stimulus
            if (hold_seen != hold_trigger)
            begin
                hold_seen = hold_trigger;
                hold_left = HOLD_CYCLES;
            end
            else if (hold_left > 0)
                hold_left--;
            rsp_stall <= (stall_left > 0) || (hold_left > 0);
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("%0t: timeout with %0d responses outstanding", $time, expected_rsps.size());
            $display("Some tests failed");
            $finish;
        end
    end

    // stimulus
    initial
    begin : stimulus
        logic [DATA_W-1:0] fill_val;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: empty list, extremes, duplicates, unused code, absent values
        queue_request(FUNC_REMOVE_ONE, 32'h0000_0000, 1'b0);
        queue_request(FUNC_REMOVE_ALL, 32'h0000_0000, 1'b0);
        queue_request(FUNC_INSERT,     32'h0000_0000, 1'b0);
        queue_request(FUNC_INSERT,     32'h7fff_ffff, 1'b0);
        queue_request(FUNC_INSERT,     32'h8000_0000, 1'b0);
        queue_request(FUNC_INSERT,     32'hffff_ffff, 1'b0);
        queue_request(FUNC_INSERT,     32'h0000_0001, 1'b0);
        queue_request(FUNC_INSERT,     32'h0000_0005, 1'b0);
        queue_request(FUNC_INSERT,     32'h0000_0005, 1'b0);
        queue_request(FUNC_INSERT,     32'h0000_0005, 1'b0);
        queue_request(FUNC_INSERT,     32'hffff_ffff, 1'b0);
        queue_request(FUNC_UNUSED,     32'h0000_0005, 1'b0);
        queue_request(FUNC_REMOVE_ONE, 32'h0000_0005, 1'b0);
        queue_request(FUNC_REMOVE_ALL, 32'h0000_0005, 1'b0);
        queue_request(FUNC_REMOVE_ALL, 32'h0000_0005, 1'b0);
        queue_request(FUNC_REMOVE_ONE, 32'h0000_004d, 1'b0);
        queue_request(FUNC_REMOVE_ONE, 32'h8000_0000, 1'b0);
        queue_request(FUNC_REMOVE_ALL, 32'h7fff_ffff, 1'b0);
        queue_request(FUNC_REMOVE_ALL, 32'hffff_ffff, 1'b0);
        queue_request(FUNC_INSERT,     32'haaaa_aaaa, 1'b0);
        queue_request(FUNC_INSERT,     32'h5555_5555, 1'b0);
        queue_request(FUNC_REMOVE_ONE, 32'h5555_5555, 1'b0);
        queue_request(FUNC_REMOVE_ALL, 32'haaaa_aaaa, 1'b0);
        queue_request(FUNC_REMOVE_ALL, 32'h0000_0000, 1'b0);
        queue_request(FUNC_REMOVE_ALL, 32'h0000_0001, 1'b0);

        // list is empty now: fill with one value past capacity, then clear it
        fill_val = $urandom();
        for (int i = 0; i < CAPACITY + 2; i++)
            queue_request(FUNC_INSERT, fill_val, 1'b0);
        queue_request(FUNC_REMOVE_ALL, fill_val, 1'b0);

        // insert heavy, runs into the full list with varied data
        run_random(90, 85, 5, 5, 1'b1);

        // back-to-back items while the receiver holds off
        wait_queue_empty();
        quiet_mode = 1'b1;
        run_random(40, 40, 25, 25, 1'b0);
        hold_trigger++;
        quiet_mode = 1'b0;
        run_random(60, 40, 25, 25, 1'b0);

        // remove heavy, drains the list
        run_random(120, 25, 35, 35, 1'b1);

        // no idling on either side
        wait_queue_empty();
        quiet_mode = 1'b1;
        run_random(100, 50, 20, 20, 1'b1);
        wait_queue_empty();
        quiet_mode = 1'b0;

        run_random(50, 50, 25, 20, 1'b0);

        // wait for every response, then let the block settle
        while (pending_reqs.size() != 0 || req_valid || expected_rsps.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (expected_rsps.size() != 0)
        begin
            $display("%0t: %0d responses never arrived", $time, expected_rsps.size());
            n_errors++;
        end
        $display("Ran %0d requests in %0d cycles, %0d field errors", n_sent, cycle_count,
                 n_errors);
        $display("Saw %0d full-list rejects, %0d removals, largest removal %0d, peak size %0d",
                 full_rejects, removal_hits, peak_removed, peak_size);
        if (n_errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
